// ===== hw/rtl/trvm_pkg.sv =====
// trvm_pkg: shared types and constants for the tagged-register execute block
// no dependencies
package trvm_pkg;

  localparam int unsigned WordW = 16;
  localparam int unsigned FixW  = 13;
  localparam int unsigned AddrW = 14;
  localparam int unsigned RegW  = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [WordW-1:0] ImmBit  = 16'h8000;
  localparam logic [WordW-1:0] ValMask = 16'h7fff;
  localparam logic [WordW-1:0] EnumTag = 16'h8002;

  // host access codes
  localparam logic [1:0] OpExec  = 2'd0;
  localparam logic [1:0] OpHeapW = 2'd1;
  localparam logic [1:0] OpHeapR = 2'd2;
  localparam logic [1:0] OpRegW  = 2'd3;

  // config register indexes
  localparam logic [CfgIdxW-1:0] CfgTrue  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFalse = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgPair  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgFree  = 2'd3;

  // opcodes
  localparam logic [7:0] OcCall  = 8'd1;
  localparam logic [7:0] OcMov   = 8'd2;
  localparam logic [7:0] OcLdi   = 8'd3;
  localparam logic [7:0] OcEnter = 8'd4;
  localparam logic [7:0] OcRet   = 8'd5;
  localparam logic [7:0] OcLde   = 8'd6;
  localparam logic [7:0] OcEq    = 8'd7;
  localparam logic [7:0] OcArity = 8'd8;
  localparam logic [7:0] OcJeq   = 8'd9;
  localparam logic [7:0] OcEnum  = 8'd10;
  localparam logic [7:0] OcFix   = 8'd11;
  localparam logic [7:0] OcAdd   = 8'd12;
  localparam logic [7:0] OcMul   = 8'd13;
  localparam logic [7:0] OcSub   = 8'd14;
  localparam logic [7:0] OcDiv   = 8'd15;
  localparam logic [7:0] OcAnd   = 8'd16;
  localparam logic [7:0] OcJif   = 8'd17;
  localparam logic [7:0] OcCar   = 8'd18;
  localparam logic [7:0] OcCdr   = 8'd19;
  localparam logic [7:0] OcCons  = 8'd20;
  localparam logic [7:0] OcEmit  = 8'd21;
  localparam logic [7:0] OcOr    = 8'd22;
  localparam logic [7:0] OcXor   = 8'd23;

  typedef enum logic [2:0] {
    ActAdvance = 3'd0,
    ActJump    = 3'd1,
    ActApply   = 3'd2,
    ActBadOp   = 3'd3,
    ActArity   = 3'd4,
    ActDivZero = 3'd5,
    ActHeapFul = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StDiv,
    StCons,
    StHeapRd,
    StOut
  } state_e;

  typedef struct packed {
    logic [1:0]       op;
    logic [7:0]       opcode;
    logic [7:0]       arg_a;
    logic [7:0]       arg_b;
    logic [AddrW-1:0] address;
    logic [RegW-1:0]  reg_index;
    logic [WordW-1:0] write_data;
    logic             emit_accepted;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [7:0]       ip_advance;
    logic [WordW-1:0] call_target;
    logic [7:0]       arg_count;
    logic [WordW-1:0] read_data;
    logic             emit_valid;
    logic [FixW-1:0]  emit_value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;     // capture input item
    logic exec;      // run first step of instruction
    logic div_start;
    logic div_step;
    logic cons_step;
    logic heap_fin;  // finish heap-read instruction
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;
    logic need_cons;
    logic need_heap;
    logic div_done;
    logic cons_done;
  } stat_t;

  function automatic logic [FixW-1:0] fixval(input logic [WordW-1:0] w);
    logic [WordW-1:0] m;
    m = w & ValMask;
    return m[FixW+1:2];
  endfunction

  function automatic logic [WordW-1:0] mkfix(input logic [FixW-1:0] v);
    return {1'b1, v, 2'b00};
  endfunction

endpackage

// ===== hw/rtl/trvm_if.sv =====
// trvm_if: valid/ready channel carrying one payload item
// depends on trvm_pkg for payload types
interface trvm_if #(
  parameter type T = trvm_pkg::in_item_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/trvm_ctrl.sv =====
// trvm_ctrl: sequencing state machine of the execute block
// depends on trvm_pkg
module trvm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  trvm_pkg::stat_t  stat_i,
  output trvm_pkg::cmd_t   cmd_o
);

  trvm_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= trvm_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      trvm_pkg::StIdle: begin
        if (in_valid_i) state_d = trvm_pkg::StExec;
      end
      trvm_pkg::StExec: begin
        if (stat_i.need_div) state_d = trvm_pkg::StDiv;
        else if (stat_i.need_cons) state_d = trvm_pkg::StCons;
        else if (stat_i.need_heap) state_d = trvm_pkg::StHeapRd;
        else state_d = trvm_pkg::StOut;
      end
      trvm_pkg::StDiv: begin
        if (stat_i.div_done) state_d = trvm_pkg::StOut;
      end
      trvm_pkg::StCons: begin
        if (stat_i.cons_done) state_d = trvm_pkg::StOut;
      end
      trvm_pkg::StHeapRd: state_d = trvm_pkg::StOut;
      trvm_pkg::StOut: begin
        if (out_ready_i) state_d = in_valid_i ? trvm_pkg::StExec : trvm_pkg::StIdle;
      end
      default: state_d = trvm_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      trvm_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.latch  = in_valid_i;
      end
      trvm_pkg::StExec: begin
        cmd_o.exec      = 1'b1;
        cmd_o.div_start = stat_i.need_div;
      end
      trvm_pkg::StDiv:    cmd_o.div_step  = 1'b1;
      trvm_pkg::StCons:   cmd_o.cons_step = 1'b1;
      trvm_pkg::StHeapRd: cmd_o.heap_fin  = 1'b1;
      trvm_pkg::StOut: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        cmd_o.latch = out_ready_i && in_valid_i;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/trvm_dp.sv =====
// trvm_dp: register file, heap memory, fixnum alu, divider and result register
// depends on trvm_pkg
module trvm_dp #(
  parameter int unsigned HEAP_WORDS = 16384,
  parameter int unsigned NUM_REGS   = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  trvm_pkg::in_item_t   in_i,
  input  trvm_pkg::cmd_t       cmd_i,
  output trvm_pkg::stat_t      stat_o,
  output trvm_pkg::out_item_t  out_o
);

  localparam int unsigned HaW = $clog2(HEAP_WORDS);
  localparam int unsigned RiW = $clog2(NUM_REGS);
  localparam int unsigned W   = trvm_pkg::WordW;
  localparam int unsigned FW  = trvm_pkg::FixW;
  localparam int unsigned AW  = trvm_pkg::AddrW;

  // reciprocal of the heap size, exact quotient for any 14-bit address
  localparam int unsigned RecipSh = 28;
  localparam logic [47:0] Recip =
      48'(((64'd1 << RecipSh) + 64'(HEAP_WORDS) - 64'd1) / 64'(HEAP_WORDS));

  // address modulo heap size
  function automatic logic [HaW-1:0] heap_idx(input logic [AW-1:0] a);
    logic [47:0] p;
    logic [31:0] q;
    logic [31:0] r;
    p = 48'(a) * Recip;
    q = 32'(p >> RecipSh);
    r = 32'(a) - q * 32'(HEAP_WORDS);
    return r[HaW-1:0];
  endfunction

  logic [W-1:0]  true_q, false_q, pair_q;
  logic [AW-1:0] fp_q;
  logic [7:0]    argc_q;
  logic [W-1:0]  rf_q [NUM_REGS];
  logic [W-1:0]  heap [HEAP_WORDS];
  logic [W-1:0]  heap_rd_q;

  trvm_pkg::in_item_t  it_q;
  trvm_pkg::out_item_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) it_q <= in_i;
  end

  logic [3:0] hi, lo, dst;
  logic [W-1:0] ra, rb, r0;
  assign hi  = it_q.arg_a[7:4];
  assign lo  = it_q.arg_a[3:0];
  assign dst = it_q.arg_b[3:0];
  assign ra  = rf_q[hi[RiW-1:0]];
  assign rb  = rf_q[lo[RiW-1:0]];
  assign r0  = rf_q[0];

  // heap address for the read-type instructions
  logic [AW-1:0] rd_sum;
  always_comb begin
    rd_sum = it_q.address;
    if (it_q.op == trvm_pkg::OpExec) begin
      unique case (it_q.opcode)
        trvm_pkg::OcLdi: rd_sum = ra[AW-1:0] + AW'(it_q.arg_b);
        trvm_pkg::OcLde: rd_sum = r0[AW-1:0] + AW'(hi);
        trvm_pkg::OcCar: rd_sum = ra[AW-1:0] + AW'(1);
        trvm_pkg::OcCdr: rd_sum = ra[AW-1:0] + AW'(2);
        default:         rd_sum = it_q.address;
      endcase
    end
  end

  logic is_load;
  assign is_load = (it_q.op == trvm_pkg::OpExec) &&
      (it_q.opcode == trvm_pkg::OcLdi || it_q.opcode == trvm_pkg::OcLde ||
       it_q.opcode == trvm_pkg::OcCar || it_q.opcode == trvm_pkg::OcCdr);

  // cons sequencing: three heap writes
  logic [1:0]  cons_cnt_q;
  logic [FW-1:0] fa, fb;
  assign fa = trvm_pkg::fixval(ra);
  assign fb = trvm_pkg::fixval(rb);

  logic heap_full;
  assign heap_full = ({1'b0, fp_q} + 15'd3) > 15'(HEAP_WORDS);

  logic exec_op;
  assign exec_op = it_q.op == trvm_pkg::OpExec;

  assign stat_o.need_div  = exec_op && it_q.opcode == trvm_pkg::OcDiv && fb != '0;
  assign stat_o.need_cons = exec_op && it_q.opcode == trvm_pkg::OcCons && !heap_full;
  assign stat_o.need_heap = is_load || it_q.op == trvm_pkg::OpHeapR;

  // heap memory: one write and one registered read port
  logic          hw_en;
  logic [HaW-1:0] hw_addr;
  logic [W-1:0]  hw_data;
  always_comb begin
    hw_en   = 1'b0;
    hw_addr = heap_idx(it_q.address);
    hw_data = it_q.write_data;
    if (cmd_i.exec && it_q.op == trvm_pkg::OpHeapW) begin
      hw_en = 1'b1;
    end else if (cmd_i.cons_step) begin
      hw_en   = 1'b1;
      hw_addr = HaW'(fp_q + AW'(cons_cnt_q));
      case (cons_cnt_q)
        2'd0:    hw_data = pair_q;
        2'd1:    hw_data = ra;
        default: hw_data = rb;
      endcase
    end
  end

  logic [AW-1:0] rd_full;
  assign rd_full = rd_sum;
  always_ff @(posedge clk_i) begin
    if (hw_en) heap[hw_addr] <= hw_data;
    heap_rd_q <= heap[heap_idx(rd_full)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cons_cnt_q <= '0;
    else if (cmd_i.cons_step) cons_cnt_q <= (cons_cnt_q == 2'd2) ? 2'd0 : cons_cnt_q + 2'd1;
  end
  assign stat_o.cons_done = cons_cnt_q == 2'd2;

  // restoring divider, one quotient bit a cycle
  logic [FW-1:0]  dq_q, dr_q, dd_q;
  logic [3:0]     dcnt_q;
  logic [FW:0]    dtrial;
  assign dtrial = {dr_q, dq_q[FW-1]} - {1'b0, dd_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 4'(FW);
    end else if (cmd_i.div_step && dcnt_q != 0) begin
      dcnt_q <= dcnt_q - 4'd1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= fa;
      dr_q <= '0;
      dd_q <= fb;
    end else if (cmd_i.div_step && dcnt_q != 0) begin
      if (!dtrial[FW]) begin
        dr_q <= dtrial[FW-1:0];
        dq_q <= {dq_q[FW-2:0], 1'b1};
      end else begin
        dr_q <= {dr_q[FW-2:0], dq_q[FW-1]};
        dq_q <= {dq_q[FW-2:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = dcnt_q == 4'd1;

  // product of 13-bit fields, truncated
  logic [2*FW-1:0] prod;
  assign prod = fa * fb;

  // first-step evaluation of register writes and results
  logic          rw_en;
  logic [3:0]    rw_idx;
  logic [W-1:0]  rw_data;
  logic          r2_en;
  logic [W-1:0]  r2_data;
  logic          argc_en;
  logic [7:0]    argc_new;
  logic          fp_en;
  trvm_pkg::out_item_t res;

  always_comb begin
    rw_en = 1'b0; rw_idx = lo; rw_data = '0;
    r2_en = 1'b0; r2_data = rb;
    argc_en = 1'b0; argc_new = argc_q;
    fp_en = 1'b0;
    res = '0;
    if (it_q.op == trvm_pkg::OpRegW) begin
      rw_en = 1'b1; rw_idx = it_q.reg_index; rw_data = it_q.write_data;
    end else if (exec_op) begin
      unique case (it_q.opcode)
        trvm_pkg::OcCall: begin
          argc_en = 1'b1; argc_new = {4'd0, lo};
          rw_en = 1'b1; rw_idx = 4'd0; rw_data = ra;
          res.action = trvm_pkg::ActApply;
          res.call_target = ra; res.arg_count = {4'd0, lo};
        end
        trvm_pkg::OcMov: begin
          rw_en = 1'b1; rw_data = ra; res.ip_advance = 8'd2;
        end
        trvm_pkg::OcEnter: begin
          argc_en = 1'b1; argc_new = it_q.arg_a;
          res.action = trvm_pkg::ActApply;
          res.call_target = r0; res.arg_count = it_q.arg_a;
        end
        trvm_pkg::OcRet: begin
          rw_en = 1'b1; rw_idx = 4'd0; rw_data = rf_q[2];
          // source register 0 already holds the old r2
          r2_en = 1'b1; r2_data = (lo == 4'd0) ? rf_q[2] : rb;
          argc_en = 1'b1; argc_new = {4'd0, hi};
          res.action = trvm_pkg::ActApply;
          res.call_target = rf_q[2];
          res.arg_count = {4'd0, hi};
        end
        trvm_pkg::OcEq: begin
          rw_en = 1'b1; rw_idx = dst;
          rw_data = (ra == rb) ? true_q : false_q; res.ip_advance = 8'd3;
        end
        trvm_pkg::OcArity: begin
          if (argc_q != it_q.arg_a) begin
            res.action = trvm_pkg::ActArity; res.arg_count = argc_q;
          end else res.ip_advance = 8'd2;
        end
        trvm_pkg::OcJeq: begin
          if (ra == rb) begin
            res.action = trvm_pkg::ActJump; res.ip_advance = it_q.arg_b;
          end else res.ip_advance = 8'd3;
        end
        trvm_pkg::OcEnum: begin
          rw_en = 1'b1; rw_data = trvm_pkg::EnumTag | W'({hi, 2'b00});
          res.ip_advance = 8'd2;
        end
        trvm_pkg::OcFix: begin
          rw_en = 1'b1; rw_data = trvm_pkg::mkfix(FW'(hi)); res.ip_advance = 8'd2;
        end
        trvm_pkg::OcAdd: begin
          rw_en = 1'b1; rw_idx = dst; rw_data = trvm_pkg::mkfix(fa + fb);
          res.ip_advance = 8'd3;
        end
        trvm_pkg::OcMul: begin
          rw_en = 1'b1; rw_idx = dst; rw_data = trvm_pkg::mkfix(prod[FW-1:0]);
          res.ip_advance = 8'd3;
        end
        trvm_pkg::OcSub: begin
          rw_en = 1'b1; rw_idx = dst; rw_data = trvm_pkg::mkfix(fa - fb);
          res.ip_advance = 8'd3;
        end
        trvm_pkg::OcDiv: begin
          if (fb == '0) res.action = trvm_pkg::ActDivZero;
          else res.ip_advance = 8'd3;
        end
        trvm_pkg::OcAnd: begin
          rw_en = 1'b1; rw_idx = dst; rw_data = ra & rb; res.ip_advance = 8'd3;
        end
        trvm_pkg::OcOr: begin
          rw_en = 1'b1; rw_idx = dst; rw_data = ra | rb; res.ip_advance = 8'd3;
        end
        trvm_pkg::OcXor: begin
          rw_en = 1'b1; rw_idx = dst; rw_data = (ra ^ rb) | trvm_pkg::ImmBit;
          res.ip_advance = 8'd3;
        end
        trvm_pkg::OcJif: begin
          if (rb == false_q) res.ip_advance = 8'd3;
          else begin
            res.action = trvm_pkg::ActJump; res.ip_advance = it_q.arg_b;
          end
        end
        trvm_pkg::OcCons: begin
          if (heap_full) res.action = trvm_pkg::ActHeapFul;
          else res.ip_advance = 8'd3;
        end
        trvm_pkg::OcEmit: begin
          res.emit_valid = 1'b1; res.emit_value = fa;
          rw_en = 1'b1; rw_data = it_q.emit_accepted ? true_q : false_q;
          res.ip_advance = 8'd2;
        end
        trvm_pkg::OcLdi: res.ip_advance = 8'd3;
        trvm_pkg::OcLde, trvm_pkg::OcCar, trvm_pkg::OcCdr: res.ip_advance = 8'd2;
        default: res.action = trvm_pkg::ActBadOp;
      endcase
    end
  end

  // register file, config, argument count and free pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) rf_q[i] <= '0;
      argc_q  <= 8'd3;
      true_q  <= 16'h8006;
      false_q <= 16'h800a;
      pair_q  <= 16'h810f;
      fp_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          trvm_pkg::CfgTrue:  true_q  <= cfg_data_i;
          trvm_pkg::CfgFalse: false_q <= cfg_data_i;
          trvm_pkg::CfgPair:  pair_q  <= cfg_data_i;
          default:            fp_q    <= cfg_data_i[AW-1:0];
        endcase
      end
      if (cmd_i.exec) begin
        if (rw_en) rf_q[rw_idx[RiW-1:0]] <= rw_data;
        if (r2_en) rf_q[2] <= r2_data;
        if (argc_en) argc_q <= argc_new;
      end
      if (cmd_i.heap_fin && is_load) rf_q[lo[RiW-1:0]] <= heap_rd_q;
      if (cmd_i.div_step && dcnt_q == 4'd1) begin
        if (!dtrial[FW]) rf_q[dst[RiW-1:0]] <= trvm_pkg::mkfix({dq_q[FW-2:0], 1'b1});
        else rf_q[dst[RiW-1:0]] <= trvm_pkg::mkfix({dq_q[FW-2:0], 1'b0});
      end
      if (cmd_i.cons_step && cons_cnt_q == 2'd2) begin
        rf_q[dst[RiW-1:0]] <= W'(fp_q);
        fp_q <= fp_q + AW'(3);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) res_q <= res;
    if (cmd_i.heap_fin && it_q.op == trvm_pkg::OpHeapR) res_q.read_data <= heap_rd_q;
  end

  assign out_o = res_q;

endmodule

// ===== hw/rtl/tagged_register_vm_execute.sv =====
// tagged_register_vm_execute: one-instruction execute unit of a tagged-word machine
// loads and host reads pass StHeapRd before the result; cons StCons; nonzero divide StDiv
// one item at a time, next item accepted in the cycle its result is taken
// divide length is set by the one-bit-a-cycle divider, cons by the single heap write port
// reset clears registers to zero, argument count to 3, config to defaults; heap undefined
module tagged_register_vm_execute #(
  parameter int unsigned HEAP_WORDS = 16384,
  parameter int unsigned NUM_REGS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  trvm_if.sink        in_ch,
  trvm_if.source      out_ch
);

  trvm_pkg::cmd_t  cmd;
  trvm_pkg::stat_t stat;

  trvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  trvm_dp #(
    .HEAP_WORDS (HEAP_WORDS),
    .NUM_REGS   (NUM_REGS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_o      (out_ch.data)
  );

  // input is only taken when no result is pending or it is being taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while result stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec, cmd.div_step, cmd.cons_step, cmd.heap_fin}))
    else $error("overlapping datapath commands");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.latch |=> cmd.exec)
    else $error("latched item not executed");

endmodule
